@@ sv/lbcc_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU block cache controller package
// Command and status codes, field widths and the per-cell update controls
// shared by the cache controller, its slot cells and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package lbcc_pkg;

    // Field widths of the request, result and configuration.
    localparam int CMD_W    = 3;
    localparam int BLK_W    = 32;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;
    localparam int SECTOR_W = 35;
    localparam int REFS_W   = 8;
    localparam int CFG_W    = 7;

    // Reset value of the usable slot count register.
    localparam logic [CFG_W-1:0] ENTRIES_RESET = 7'd64;

    // Largest reference count a slot can hold.
    localparam logic [REFS_W-1:0] REFS_MAX = 8'd255;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DIRTY   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd5;

    // Update controls broadcast to every slot cell when a request commits.
    typedef struct packed {
        logic en;          // commit this cycle
        logic mru;         // move the target slot to most recent
        logic inc;         // target reference count plus one
        logic dec;         // target reference count minus one, saturating at zero
        logic set_dirty;   // target dirty bit set
        logic fill;        // target takes the requested block
        logic fill_ref;    // new block starts with one reference
        logic fill_dirty;  // new block starts dirty
    } t_upd;

endpackage

`default_nettype wire

@@ sv/lbcc_if.sv @@
// ----------------------------------------------------------------------------
// LRU block cache controller channels
// Valid/ready interfaces for the request channel and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbcc_req_if;
    logic                         valid;
    logic                         ready;
    logic [lbcc_pkg::CMD_W-1:0]   command;
    logic [lbcc_pkg::BLK_W-1:0]   block_number;
    logic [lbcc_pkg::SLOT_W-1:0]  slot;

    modport source (output valid, command, block_number, slot, input ready);
    modport sink   (input valid, command, block_number, slot, output ready);
endinterface

interface lbcc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lbcc_pkg::STATUS_W-1:0] status;
    logic [lbcc_pkg::SLOT_W-1:0]   granted_slot;
    logic                          writeback_valid;
    logic [lbcc_pkg::SECTOR_W-1:0] writeback_sector;
    logic                          fill_valid;
    logic [lbcc_pkg::SECTOR_W-1:0] fill_sector;

    modport source (output valid, status, granted_slot, writeback_valid, writeback_sector,
                    fill_valid, fill_sector, input ready);
    modport sink   (input valid, status, granted_slot, writeback_valid, writeback_sector,
                    fill_valid, fill_sector, output ready);
endinterface

`default_nettype wire

@@ sv/lbcc_cell.sv @@
// ----------------------------------------------------------------------------
// LRU block cache slot cell
// Holds one slot's tag, valid, dirty, reference count and LRU rank. A search
// record passes through the row one cell per cycle; each cell folds in its own
// hit, named slot, free slot and eviction candidate and registers the record.
// ----------------------------------------------------------------------------
`default_nettype none

module lbcc_cell #(
    parameter int  MAX_SLOTS = 64,
    parameter int  IDX       = 0,
    parameter type t_scan    = logic,
    localparam int IW        = $clog2(MAX_SLOTS),
    localparam int CW        = $clog2(MAX_SLOTS + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_scan                        i_scan,
    output t_scan                             o_scan,
    input  wire logic [lbcc_pkg::BLK_W-1:0]   i_blk,
    input  wire logic [lbcc_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic [CW-1:0]                i_cap,
    input  wire lbcc_pkg::t_upd               i_upd,
    input  wire logic [IW-1:0]                i_tgt_idx,
    input  wire logic [IW-1:0]                i_tgt_rank
);

    localparam int SW = (IW > lbcc_pkg::SLOT_W) ? IW : lbcc_pkg::SLOT_W;

    logic [lbcc_pkg::BLK_W-1:0]  r_tag;
    logic                        r_valid;
    logic                        r_dirty;
    logic [lbcc_pkg::REFS_W-1:0] r_refs;
    logic [IW-1:0]               r_rank;
    t_scan                       r_scan;
    t_scan                       n_scan;
    logic                        w_below_cap;
    logic                        w_named;
    logic                        w_target;

    assign w_below_cap = CW'(IDX) < i_cap;
    assign w_named     = SW'(IDX) == SW'(i_slot);
    assign w_target    = i_tgt_idx == IW'(IDX);

    // Fold this slot into the search record.
    always_comb begin
        n_scan = i_scan;
        if (r_valid && r_tag == i_blk) begin
            n_scan.hit      = 1'b1;
            n_scan.hit_idx  = IW'(IDX);
            n_scan.hit_full = r_refs == lbcc_pkg::REFS_MAX;
            n_scan.hit_rank = r_rank;
        end
        if (r_valid && w_named) begin
            n_scan.nam_ok   = 1'b1;
            n_scan.nam_rank = r_rank;
        end
        if (w_below_cap && !r_valid && !i_scan.fre) begin
            n_scan.fre      = 1'b1;
            n_scan.fre_idx  = IW'(IDX);
            n_scan.fre_rank = r_rank;
        end
        if (w_below_cap && r_valid && r_refs == '0 &&
            (!i_scan.vic || r_rank > i_scan.vic_rank)) begin
            n_scan.vic       = 1'b1;
            n_scan.vic_idx   = IW'(IDX);
            n_scan.vic_rank  = r_rank;
            n_scan.vic_dirty = r_dirty;
            n_scan.vic_tag   = r_tag;
        end
    end

    // Search record register toward the next cell.
    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    assign o_scan = r_scan;

    // Slot state and LRU rank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_refs  <= '0;
            r_rank  <= IW'(IDX);
        end else if (i_upd.en) begin
            if (i_upd.mru) begin
                if (w_target) begin
                    r_rank <= '0;
                end else if (r_rank < i_tgt_rank) begin
                    r_rank <= r_rank + 1'b1;
                end
            end
            if (w_target) begin
                if (i_upd.fill) begin
                    r_valid <= 1'b1;
                    r_refs  <= i_upd.fill_ref ? lbcc_pkg::REFS_W'(1) : '0;
                    r_dirty <= i_upd.fill_dirty;
                end
                if (i_upd.inc) begin
                    r_refs <= r_refs + 1'b1;
                end
                if (i_upd.dec && r_refs != '0) begin
                    r_refs <= r_refs - 1'b1;
                end
                if (i_upd.set_dirty) begin
                    r_dirty <= 1'b1;
                end
            end
        end
    end

    // Block number of the slot, written on fill.
    always_ff @(posedge i_clk) begin
        if (i_upd.en && i_upd.fill && w_target) begin
            r_tag <= i_blk;
        end
    end

endmodule

`default_nettype wire

@@ sv/lru_block_cache_controller.sv @@
// Timing: a request is taken in idle and the search record walks the row of
// slot cells at one cell per cycle; the decide state then updates all cells at
// once and registers the result, waiting while an earlier result is unaccepted.
// Requests are taken only in idle; unknown commands are dropped with no result.
// Reset: all slots empty, ranks equal to slot index, usable slots 64.
// ----------------------------------------------------------------------------
// LRU block cache controller
// Tag and replacement controller for a disk block cache built as a row of
// slot cells, with hit, fill, writeback and reference count handling.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_block_cache_controller #(
    parameter int MAX_SLOTS         = 64,
    parameter int SECTORS_PER_BLOCK = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    lbcc_req_if.sink                          i_req,
    lbcc_rsp_if.source                        o_rsp,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [lbcc_pkg::CFG_W-1:0]   i_cfg_wr_data
);

    localparam int IW    = $clog2(MAX_SLOTS);
    localparam int CW    = $clog2(MAX_SLOTS + 1);
    localparam int SPB_W = $clog2(SECTORS_PER_BLOCK + 1);
    localparam int PW    = lbcc_pkg::BLK_W + SPB_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    typedef struct packed {
        logic                       hit;
        logic [IW-1:0]              hit_idx;
        logic                       hit_full;
        logic [IW-1:0]              hit_rank;
        logic                       nam_ok;
        logic [IW-1:0]              nam_rank;
        logic                       fre;
        logic [IW-1:0]              fre_idx;
        logic [IW-1:0]              fre_rank;
        logic                       vic;
        logic [IW-1:0]              vic_idx;
        logic [IW-1:0]              vic_rank;
        logic                       vic_dirty;
        logic [lbcc_pkg::BLK_W-1:0] vic_tag;
    } t_scan;

    logic [1:0]                    r_state;
    logic [IW-1:0]                 r_cnt;
    logic [lbcc_pkg::CFG_W-1:0]    r_entries;
    logic [CW-1:0]                 r_filled;
    logic [lbcc_pkg::CMD_W-1:0]    r_cmd;
    logic [lbcc_pkg::BLK_W-1:0]    r_blk;
    logic [lbcc_pkg::SLOT_W-1:0]   r_slot;
    logic [CW-1:0]                 r_cap;
    logic                          r_out_valid;
    logic [lbcc_pkg::STATUS_W-1:0] r_status;
    logic [lbcc_pkg::SLOT_W-1:0]   r_granted;
    logic                          r_wb_valid;
    logic [lbcc_pkg::SECTOR_W-1:0] r_wb_sector;
    logic                          r_fill_valid;
    logic [lbcc_pkg::SECTOR_W-1:0] r_fill_sector;

    t_scan                         w_chain [MAX_SLOTS+1];
    t_scan                         w_res;
    logic [CW-1:0]                 w_cap;
    logic                          w_accept;
    logic                          w_commit;
    logic                          w_slot_cmd;
    lbcc_pkg::t_upd                w_upd;
    logic [IW-1:0]                 w_tgt_idx;
    logic [IW-1:0]                 w_tgt_rank;
    logic                          w_take_free;
    logic [lbcc_pkg::STATUS_W-1:0] w_status;
    logic [lbcc_pkg::SLOT_W-1:0]   w_granted;
    logic                          w_wb_valid;
    logic                          w_fill_valid;
    logic [PW-1:0]                 w_wb_prod;
    logic [PW-1:0]                 w_fill_prod;

    // Effective capacity: the full row when the register is zero or too large.
    always_comb begin
        if (r_entries == '0 || 32'(r_entries) > MAX_SLOTS) begin
            w_cap = CW'(MAX_SLOTS);
        end else begin
            w_cap = CW'(r_entries);
        end
    end

    assign i_req.ready = r_state == S_IDLE;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_commit    = (r_state == S_DECIDE) && (!r_out_valid || o_rsp.ready);
    assign w_slot_cmd  = r_cmd == lbcc_pkg::CMD_RELEASE || r_cmd == lbcc_pkg::CMD_DIRTY;

    // Row of slot cells; the search record enters empty at cell zero.
    assign w_chain[0] = '0;

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        lbcc_cell #(
            .MAX_SLOTS (MAX_SLOTS),
            .IDX       (g),
            .t_scan    (t_scan)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_scan     (w_chain[g]),
            .o_scan     (w_chain[g+1]),
            .i_blk      (r_blk),
            .i_slot     (r_slot),
            .i_cap      (r_cap),
            .i_upd      (w_upd),
            .i_tgt_idx  (w_tgt_idx),
            .i_tgt_rank (w_tgt_rank)
        );
    end

    assign w_res = w_chain[MAX_SLOTS];

    // Decide the outcome from the finished search record.
    always_comb begin
        w_upd        = '0;
        w_tgt_idx    = '0;
        w_tgt_rank   = '0;
        w_take_free  = 1'b0;
        w_status     = lbcc_pkg::ST_NO_FREE;
        w_granted    = '0;
        w_wb_valid   = 1'b0;
        w_fill_valid = 1'b0;
        priority if (w_slot_cmd) begin
            w_granted = r_slot;
            if (!w_res.nam_ok) begin
                w_status = lbcc_pkg::ST_EMPTY;
            end else begin
                w_status      = lbcc_pkg::ST_DONE;
                w_tgt_idx     = IW'(r_slot);
                w_tgt_rank    = w_res.nam_rank;
                w_upd.mru     = r_cmd == lbcc_pkg::CMD_RELEASE;
                w_upd.dec     = r_cmd == lbcc_pkg::CMD_RELEASE;
                w_upd.set_dirty = r_cmd == lbcc_pkg::CMD_DIRTY;
            end
        end else if (w_res.hit) begin
            w_granted  = lbcc_pkg::SLOT_W'(w_res.hit_idx);
            w_tgt_idx  = w_res.hit_idx;
            w_tgt_rank = w_res.hit_rank;
            if (w_res.hit_full) begin
                w_status = lbcc_pkg::ST_OVERFLOW;
            end else begin
                w_status        = lbcc_pkg::ST_HIT;
                w_upd.mru       = 1'b1;
                w_upd.inc       = r_cmd == lbcc_pkg::CMD_ACQUIRE;
                w_upd.set_dirty = r_cmd == lbcc_pkg::CMD_WRITE;
            end
        end else if (w_res.fre && r_filled < r_cap) begin
            w_take_free  = 1'b1;
            w_status     = lbcc_pkg::ST_MISS;
            w_granted    = lbcc_pkg::SLOT_W'(w_res.fre_idx);
            w_tgt_idx    = w_res.fre_idx;
            w_tgt_rank   = w_res.fre_rank;
            w_fill_valid = 1'b1;
            w_upd.mru    = 1'b1;
            w_upd.fill   = 1'b1;
        end else if (w_res.vic) begin
            w_status     = lbcc_pkg::ST_MISS;
            w_granted    = lbcc_pkg::SLOT_W'(w_res.vic_idx);
            w_tgt_idx    = w_res.vic_idx;
            w_tgt_rank   = w_res.vic_rank;
            w_wb_valid   = w_res.vic_dirty;
            w_fill_valid = 1'b1;
            w_upd.mru    = 1'b1;
            w_upd.fill   = 1'b1;
        end else begin
            w_status = lbcc_pkg::ST_NO_FREE;
        end
        w_upd.fill_ref   = r_cmd == lbcc_pkg::CMD_ACQUIRE;
        w_upd.fill_dirty = r_cmd == lbcc_pkg::CMD_WRITE;
        w_upd.en         = w_commit;
    end

    // Sector addresses of the evicted block and of the block to read.
    assign w_wb_prod   = PW'(w_res.vic_tag) * PW'(SECTORS_PER_BLOCK);
    assign w_fill_prod = PW'(r_blk) * PW'(SECTORS_PER_BLOCK);

    // Sequencer, configuration register, fill count and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_entries   <= lbcc_pkg::ENTRIES_RESET;
            r_filled    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_entries <= i_cfg_wr_data;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_req.command <= lbcc_pkg::CMD_WRITE) begin
                        r_state <= S_SCAN;
                        r_cnt   <= '0;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IW'(MAX_SLOTS - 1)) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                        if (w_take_free) begin
                            r_filled <= r_filled + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_req.command;
            r_blk  <= i_req.block_number;
            r_slot <= i_req.slot;
            r_cap  <= w_cap;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_status      <= w_status;
            r_granted     <= w_granted;
            r_wb_valid    <= w_wb_valid;
            r_wb_sector   <= w_wb_valid ? lbcc_pkg::SECTOR_W'(w_wb_prod) : '0;
            r_fill_valid  <= w_fill_valid;
            r_fill_sector <= w_fill_valid ? lbcc_pkg::SECTOR_W'(w_fill_prod) : '0;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_status;
    assign o_rsp.granted_slot     = r_granted;
    assign o_rsp.writeback_valid  = r_wb_valid;
    assign o_rsp.writeback_sector = r_wb_sector;
    assign o_rsp.fill_valid       = r_fill_valid;
    assign o_rsp.fill_sector      = r_fill_sector;

endmodule

`default_nettype wire
